/* hdl/sra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types, constants and helpers for the signed radix to ASCII converter.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;
  localparam int OUT_DEPTH      = 2;

  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic   neg;
    radix_t radix;
    logic   lower;
  } job_ctl_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_item_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    begin
      if (d < 4'd10) begin
        c = CHAR_ZERO + {4'd0, d};
      end else if (lower) begin
        c = CHAR_LOWER_A + {4'd0, d} - 8'd10;
      end else begin
        c = CHAR_UPPER_A + {4'd0, d} - 8'd10;
      end
      return c;
    end
  endfunction

endpackage

/* hdl/signed_radix_to_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_to_ascii
// Converts a signed number to ASCII characters in base 8, 10 or 16.
// Decimal numbers first pass through the back end's BCD converter, at 4
// double-dabble bits per cycle; octal and hex go straight to digit output.
// Throughput: one character per cycle while the output queue is not full.
// The back end converts one number at a time and takes the next from the input
// queue once the last character of the previous one is pushed. Reset empties
// both queues.
// ----------------------------------------------------------------------------
module signed_radix_to_ascii import sra_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_radix_select,
  input  logic        in_lower_case,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_char_code,
  output logic        out_last
);

  localparam int JOBW = $bits(job_ctl_t) + VALUE_BITS;

  job_ctl_t              front_ctl, back_ctl;
  logic [VALUE_BITS-1:0] front_mag, back_mag;
  logic                  job_empty, job_pop;
  logic                  res_full, res_push;
  out_item_t             res_item, res_head;

  sra_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .value        (in_value),
    .radix_select (in_radix_select),
    .lower_case   (in_lower_case),
    .ctl          (front_ctl),
    .mag          (front_mag)
  );

  sra_fifo #(.WIDTH(JOBW), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   ({front_ctl, front_mag}),
    .full  (in_full),
    .pop   (job_pop),
    .dout  ({back_ctl, back_mag}),
    .empty (job_empty)
  );

  sra_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_ctl   (back_ctl),
    .job_mag   (back_mag),
    .job_pop   (job_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_item  (res_item)
  );

  sra_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_item),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_head),
    .empty (out_empty)
  );

  assign out_char_code = res_head.char_code;
  assign out_last      = res_head.last;

endmodule

/* hdl/sra_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_fifo
// Small register-based queue with full and empty flags.
// ----------------------------------------------------------------------------
module sra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* hdl/sra_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_front
// Classifies an incoming number: sign, magnitude, radix and letter case.
// ----------------------------------------------------------------------------
module sra_front import sra_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [63:0]           value,
  input  logic [1:0]            radix_select,
  input  logic                  lower_case,
  output job_ctl_t              ctl,
  output logic [VALUE_BITS-1:0] mag
);

  logic [VALUE_BITS-1:0] v;
  logic                  neg;

  assign v   = value[VALUE_BITS-1:0];
  assign neg = v[VALUE_BITS-1];
  // The most negative value negates to itself, which read unsigned is 2^(N-1).
  assign mag = neg ? ((~v) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;

  always_comb begin
    ctl.neg   = neg;
    ctl.lower = lower_case;
    case (radix_t'(radix_select))
      RADIX_OCT: ctl.radix = RADIX_OCT;
      RADIX_DEC: ctl.radix = RADIX_DEC;
      default:   ctl.radix = RADIX_HEX;
    endcase
  end

endmodule

/* hdl/sra_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_back
// Turns one classified magnitude into digits and emits the characters.
// ----------------------------------------------------------------------------
module sra_back import sra_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_empty,
  input  job_ctl_t              job_ctl,
  input  logic [VALUE_BITS-1:0] job_mag,
  output logic                  job_pop,
  input  logic                  out_full,
  output logic                  out_push,
  output out_item_t             out_item
);

  localparam int NDIG  = (VALUE_BITS + 2) / 3;     // octal digits, the most of any radix
  localparam int HDIG  = (VALUE_BITS + 3) / 4;     // hex digits, also four-step dabble passes
  localparam int OCTW  = 3 * NDIG;
  localparam int SHW   = 4 * HDIG;
  localparam int DW    = 4 * NDIG;
  localparam int IDXW  = $clog2(NDIG);
  localparam int STEPW = (HDIG > 1) ? $clog2(HDIG) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [DW-1:0]    digits_r, digits_nxt;
  logic [SHW-1:0]   shreg_r, shreg_nxt;
  logic [STEPW-1:0] step_r, step_nxt;
  logic [IDXW-1:0]  idx_r, idx_nxt;
  logic             neg_r, neg_nxt;
  logic             lower_r, lower_nxt;

  logic [OCTW-1:0]  mag_oct;
  logic [SHW-1:0]   mag_hex;
  logic [DW-1:0]    load_oct, load_hex, dab;
  logic [IDXW-1:0]  top_idx;
  logic [3:0]       cur_digit;

  assign mag_oct   = OCTW'(job_mag);
  assign mag_hex   = SHW'(job_mag);
  assign cur_digit = digits_r[4*idx_r +: 4];

  always_comb begin
    load_oct = '0;
    load_hex = '0;
    for (int i = 0; i < NDIG; i++) begin
      load_oct[4*i +: 4] = {1'b0, mag_oct[3*i +: 3]};
    end
    for (int i = 0; i < HDIG; i++) begin
      load_hex[4*i +: 4] = mag_hex[4*i +: 4];
    end
  end

  // Four double-dabble steps per cycle: correct each BCD digit, then shift in
  // the next magnitude bit.
  always_comb begin
    dab = digits_r;
    for (int b = 3; b >= 0; b--) begin
      for (int i = 0; i < NDIG; i++) begin
        if (dab[4*i +: 4] >= 4'd5) begin
          dab[4*i +: 4] = dab[4*i +: 4] + 4'd3;
        end
      end
      dab = {dab[DW-2:0], shreg_r[SHW-4+b]};
    end
  end

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (digits_r[4*i +: 4] != 4'd0) begin
        top_idx = IDXW'(i);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    digits_nxt = digits_r;
    shreg_nxt  = shreg_r;
    step_nxt   = step_r;
    idx_nxt    = idx_r;
    neg_nxt    = neg_r;
    lower_nxt  = lower_r;
    job_pop    = 1'b0;
    out_push   = 1'b0;
    out_item   = '{char_code: CHAR_MINUS, last: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          neg_nxt   = job_ctl.neg;
          lower_nxt = job_ctl.lower;
          shreg_nxt = mag_hex;
          step_nxt  = '0;
          case (job_ctl.radix)
            RADIX_DEC: begin
              digits_nxt = '0;
              state_nxt  = ST_CONV;
            end
            RADIX_OCT: begin
              digits_nxt = load_oct;
              state_nxt  = ST_COUNT;
            end
            default: begin
              digits_nxt = load_hex;
              state_nxt  = ST_COUNT;
            end
          endcase
        end
      end
      ST_CONV: begin
        digits_nxt = dab;
        shreg_nxt  = shreg_r << 4;
        step_nxt   = step_r + 1'b1;
        if (step_r == STEPW'(HDIG - 1)) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        idx_nxt   = top_idx;
        state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (!out_full) begin
          out_push  = 1'b1;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_item = '{char_code: digit_char(cur_digit, lower_r), last: (idx_r == '0)};
        if (!out_full) begin
          out_push = 1'b1;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    digits_r <= digits_nxt;
    shreg_r  <= shreg_nxt;
    step_r   <= step_nxt;
    idx_r    <= idx_nxt;
    neg_r    <= neg_nxt;
    lower_r  <= lower_nxt;
  end

endmodule
